// ===== hdl/lpbe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbe_pkg
// Shared types and constants of the LED pulse bit expander.
// ----------------------------------------------------------------------------
package lpbe_pkg;

   localparam int WORD_W   = 64;
   localparam int PAT_W    = 40;
   localparam int FILL_W   = 6;
   localparam int BYTES_W  = 4;
   localparam int PAD_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPANSION_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_WORD_COUNT = 1'd1;

   localparam logic [PAD_W-1:0]   PAD_COUNT_RESET = 4'd15;
   localparam logic [BYTES_W-1:0] FULL_WORD_BYTES = 4'd8;

   typedef struct packed {
      logic [7:0] color_byte;
      logic       frame_start;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  spi_word;
      logic [BYTES_W-1:0] valid_bytes;
      logic               word_is_last;
   } rsp_type;

   // words owed for one request, in emission order
   typedef struct packed {
      logic [PAD_W-1:0]   lead_cnt;
      logic               has_full;
      logic [WORD_W-1:0]  full_word;
      logic               has_flush;
      logic [WORD_W-1:0]  flush_word;
      logic [BYTES_W-1:0] flush_bytes;
      logic [PAD_W-1:0]   trail_cnt;
      logic               frame_end;
   } plan_type;

endpackage

// ===== hdl/lpbe_pack.sv =====
// ----------------------------------------------------------------------------
// lpbe_pack
// Expands one color byte into its pulse pattern and packs it into the
// accumulator; produces the list of words the request owes.
// ----------------------------------------------------------------------------
module lpbe_pack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mode,
   input  logic [lpbe_pkg::PAD_W-1:0]    pad_count,
   input  lpbe_pkg::req_type             req,
   input  logic                          accept,
   output lpbe_pkg::plan_type            plan,
   output logic                          plan_nonempty,
   output logic [lpbe_pkg::FILL_W-1:0]   fill_bits
);

   logic [lpbe_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic [lpbe_pkg::FILL_W-1:0] fill_ff, fill_in;

   logic [lpbe_pkg::PAT_W-1:0]  pat3, pat5, pat;
   logic [lpbe_pkg::FILL_W-1:0] pat_len;
   logic [lpbe_pkg::WORD_W-1:0] base_acc;
   logic [lpbe_pkg::FILL_W-1:0] base_fill;
   logic [2*lpbe_pkg::WORD_W-1:0] window;
   logic [lpbe_pkg::FILL_W:0]   total;
   logic                        word_full;
   logic [lpbe_pkg::WORD_W-1:0] rem_word;
   logic [lpbe_pkg::FILL_W-1:0] rem_fill;
   logic [lpbe_pkg::FILL_W:0]   round_up;

   // three-bit mode: 1,b,0 per data bit
   always_comb begin
      pat3 = '0;
      for (int i = 0; i < 8; i++) begin
         pat3[lpbe_pkg::PAT_W-1-3*i -: 3] = {1'b1, req.color_byte[7-i], 1'b0};
      end
   end

   // five-slot mode: 11100 for a one, 1000 for a zero
   always_comb begin
      logic [lpbe_pkg::FILL_W-1:0] off;
      logic [4:0]                  sym;
      off  = '0;
      pat5 = '0;
      for (int i = 0; i < 8; i++) begin
         sym  = req.color_byte[7-i] ? 5'b11100 : 5'b10000;
         pat5 = pat5 | ({sym, {(lpbe_pkg::PAT_W-5){1'b0}}} >> off);
         off  = off + (req.color_byte[7-i] ? 6'd5 : 6'd4);
      end
   end

   assign pat     = mode ? pat5 : pat3;
   assign pat_len = mode ? (6'd32 + 6'($countones(req.color_byte))) : 6'd24;

   // a frame start drops whatever is pending
   assign base_acc  = req.frame_start ? '0 : acc_ff;
   assign base_fill = req.frame_start ? '0 : fill_ff;

   assign window = {base_acc, {lpbe_pkg::WORD_W{1'b0}}}
                 | ({pat, {(2*lpbe_pkg::WORD_W-lpbe_pkg::PAT_W){1'b0}}} >> base_fill);
   assign total     = {1'b0, base_fill} + {1'b0, pat_len};
   assign word_full = total[lpbe_pkg::FILL_W];
   assign rem_word  = word_full ? window[lpbe_pkg::WORD_W-1:0]
                                : window[2*lpbe_pkg::WORD_W-1:lpbe_pkg::WORD_W];
   assign rem_fill  = total[lpbe_pkg::FILL_W-1:0];
   assign round_up  = {1'b0, rem_fill} + 7'd7;

   always_comb begin
      plan.lead_cnt    = req.frame_start ? pad_count : '0;
      plan.has_full    = word_full;
      plan.full_word   = window[2*lpbe_pkg::WORD_W-1:lpbe_pkg::WORD_W];
      plan.has_flush   = req.frame_end && (rem_fill != '0);
      plan.flush_word  = rem_word;
      plan.flush_bytes = round_up[lpbe_pkg::FILL_W:3];
      plan.trail_cnt   = req.frame_end ? pad_count : '0;
      plan.frame_end   = req.frame_end;
   end

   assign plan_nonempty = (plan.lead_cnt != '0) || plan.has_full || plan.has_flush
                        || (plan.trail_cnt != '0);

   assign acc_in  = req.frame_end ? '0 : rem_word;
   assign fill_in = req.frame_end ? '0 : rem_fill;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
      end
   end

   assign fill_bits = fill_ff;

endmodule

// ===== hdl/lpbe_emit.sv =====
// ----------------------------------------------------------------------------
// lpbe_emit
// Holds the words owed by one request and hands them out one per cycle
// through the output register, whenever that register is free to take one.
// ----------------------------------------------------------------------------
module lpbe_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  lpbe_pkg::plan_type   plan,
   input  logic                 plan_nonempty,
   output logic                 in_ready,
   output logic                 plan_busy,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lpbe_pkg::rsp_type    out_data
);

   lpbe_pkg::plan_type plan_ff, plan_in;
   logic               plan_valid_ff;
   lpbe_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic               out_free, step, done;

   assign out_free = !rsp_valid_ff || out_ready;
   assign step     = plan_valid_ff && out_free;

   // pick the next word: leading pad, full word, flush word, trailing pad
   always_comb begin
      plan_in = plan_ff;
      rsp_in.spi_word    = '0;
      rsp_in.valid_bytes = lpbe_pkg::FULL_WORD_BYTES;
      if (plan_ff.lead_cnt != '0) begin
         plan_in.lead_cnt = plan_ff.lead_cnt - 4'd1;
      end else if (plan_ff.has_full) begin
         plan_in.has_full = 1'b0;
         rsp_in.spi_word  = plan_ff.full_word;
      end else if (plan_ff.has_flush) begin
         plan_in.has_flush  = 1'b0;
         rsp_in.spi_word    = plan_ff.flush_word;
         rsp_in.valid_bytes = plan_ff.flush_bytes;
      end else begin
         plan_in.trail_cnt = plan_ff.trail_cnt - 4'd1;
      end
      done = (plan_in.lead_cnt == '0) && !plan_in.has_full && !plan_in.has_flush
           && (plan_in.trail_cnt == '0);
      rsp_in.word_is_last = plan_ff.frame_end && done;
   end

   assign in_ready = !plan_valid_ff || (step && done);

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
      end else if (accept) begin
         plan_valid_ff <= plan_nonempty;
      end else if (step && done) begin
         plan_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         plan_ff <= plan;
      end else if (step) begin
         plan_ff <= plan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign plan_busy = plan_valid_ff;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ===== hdl/led_pulse_bit_expander.sv =====
// ----------------------------------------------------------------------------
// led_pulse_bit_expander
// Expands LED color bytes into SPI pulse patterns packed in 64-bit words,
// with zero pad words around each frame.
// ----------------------------------------------------------------------------
//
//  port group  direction  handshake              payload
//  req_*       in         req_valid / req_ready  req_data  (color byte, frame flags)
//  rsp_*       out        rsp_valid / rsp_ready  rsp_data  (spi word, bytes, last)
//  csr_*       in         csr_write_en           csr_index, csr_wdata
//
//  a request that yields at most one word is taken every cycle while the
//  output is not stalled; a request that yields more words holds the word
//  sequencer until its last word has gone to the output register (up to 32
//  words with leading pad, full word, flush word and trailing pad); a result
//  is registered first in the word sequencer, then in the output register;
//  a stalled output holds its word while the next request waits in the sequencer
//  reset (synchronous) clears the accumulator, fill count, valid flags and
//  sets three-bit mode with 15 pad words
//
module led_pulse_bit_expander (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lpbe_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lpbe_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_en,
   input  logic [lpbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpbe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                          mode_ff;
   logic [lpbe_pkg::PAD_W-1:0]    pad_count_ff;
   logic                          accept;
   lpbe_pkg::plan_type            plan;
   logic                          plan_nonempty;
   logic                          plan_busy;
   logic [lpbe_pkg::FILL_W-1:0]   fill_bits;

   // configuration registers; the user must write them only while idle, the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         pad_count_ff <= lpbe_pkg::PAD_COUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            lpbe_pkg::CSR_EXPANSION_MODE: mode_ff      <= csr_wdata[0];
            lpbe_pkg::CSR_PAD_WORD_COUNT: pad_count_ff <= csr_wdata[lpbe_pkg::PAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_valid && req_ready;

   // pattern expansion and packing into the accumulator
   lpbe_pack u_pack (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .pad_count     (pad_count_ff),
      .req           (req_data),
      .accept        (accept),
      .plan          (plan),
      .plan_nonempty (plan_nonempty),
      .fill_bits     (fill_bits)
   );

   // word sequencer and output register
   lpbe_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .plan          (plan),
      .plan_nonempty (plan_nonempty),
      .in_ready      (req_ready),
      .plan_busy     (plan_busy),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_data      (rsp_data)
   );

   // a frame end always leaves the accumulator empty
   assert property (@(posedge clock) disable iff (reset)
      accept && req_data.frame_end |=> fill_bits == '0)
      else $error("accumulator not empty after frame end");

   // a new word only appears when a request had words pending
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(plan_busy))
      else $error("word emitted with nothing pending");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED pulse bit expander: color bytes in frames
// go in, 64-bit SPI pulse words come out and are checked in order against
// a bit-level expansion model kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT      = 500_000;
   localparam int HOLD_AFTER_WORDS = 60;    // words seen before the long stall
   localparam int HOLD_CYCLES      = 400;   // long receiver stall
   localparam int SETTLE_CYCLES    = 40;    // sequencer can run up to 32 words
   localparam int PRINT_CAP        = 30;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // block ports, inputs all known from time zero
   logic                            req_valid    = 1'b0;
   logic                            req_ready;
   lpbe_pkg::req_type               req_data     = '0;
   logic                            rsp_valid;
   logic                            rsp_ready    = 1'b0;
   lpbe_pkg::rsp_type               rsp_data;
   logic                            csr_write_en = 1'b0;
   logic [lpbe_pkg::CSR_IDX_W-1:0]  csr_index    = '0;
   logic [lpbe_pkg::CSR_DATA_W-1:0] csr_wdata    = '0;

   led_pulse_bit_expander dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // request queue filled by the sequence below, drained by the driver
   lpbe_pkg::req_type pending_requests[$];
   // words the expansion model says must come out, oldest first
   lpbe_pkg::rsp_type expected_words[$];

   // expansion model state and its copy of the registers
   logic [lpbe_pkg::WORD_W-1:0] pulse_acc   = '0;
   int unsigned                 pulse_fill  = 0;
   logic                        mode_five   = 1'b0;
   logic [lpbe_pkg::PAD_W-1:0]  pad_words   = lpbe_pkg::PAD_COUNT_RESET;
   int                          words_this_request;

   // bookkeeping
   int  n_queued      = 0;
   int  n_accepted    = 0;
   int  words_checked = 0;
   int  error_count   = 0;
   int  settings_seen = 1;
   int  cycle_count   = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // handshake pacing
   int  req_wait  = 0;
   int  rsp_wait  = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_calm  = 1'b0;
   bit  rsp_calm  = 1'b1;

   // --------------------------------------------------------------------------
   // expansion model
   // --------------------------------------------------------------------------

   task automatic push_word(input logic [lpbe_pkg::WORD_W-1:0] word,
                            input logic [lpbe_pkg::BYTES_W-1:0] nbytes);
      lpbe_pkg::rsp_type w;
      w.spi_word     = word;
      w.valid_bytes  = nbytes;
      w.word_is_last = 1'b0;
      expected_words.push_back(w);
      words_this_request++;
   endtask

   task automatic push_pads();
      for (int i = 0; i < int'(pad_words); i++)
         push_word('0, lpbe_pkg::FULL_WORD_BYTES);
   endtask

   // one pulse bit into the accumulator, msb first; a full word goes out at once
   task automatic push_pulse(input bit b);
      if (b)
         pulse_acc[lpbe_pkg::WORD_W - 1 - pulse_fill] = 1'b1;
      pulse_fill++;
      if (pulse_fill == lpbe_pkg::WORD_W) begin
         push_word(pulse_acc, lpbe_pkg::FULL_WORD_BYTES);
         pulse_acc  = '0;
         pulse_fill = 0;
      end
   endtask

   task automatic expand_request(input lpbe_pkg::req_type r);
      bit                b;
      lpbe_pkg::rsp_type tail;
      words_this_request = 0;
      // a start throws away anything left of the previous frame
      if (r.frame_start) begin
         pulse_acc  = '0;
         pulse_fill = 0;
         push_pads();
      end
      for (int i = 7; i >= 0; i--) begin
         b = r.color_byte[i];
         push_pulse(1'b1);
         push_pulse(b);
         if (mode_five) begin
            // one: 1 1 1 0 0, zero: 1 0 0 0
            if (b)
               push_pulse(1'b1);
            push_pulse(1'b0);
            push_pulse(1'b0);
         end else begin
            // 1 b 0
            push_pulse(1'b0);
         end
      end
      if (r.frame_end) begin
         // partial word goes out padded to a whole byte
         if (pulse_fill != 0) begin
            push_word(pulse_acc, lpbe_pkg::BYTES_W'((pulse_fill + 7) / 8));
            pulse_acc  = '0;
            pulse_fill = 0;
         end
         push_pads();
         if (words_this_request > 0) begin
            tail = expected_words.pop_back();
            tail.word_is_last = 1'b1;
            expected_words.push_back(tail);
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // helpers
   // --------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_CAP)
         $display("%0t: mismatch on word %0d, %s: got %h, expected %h",
                  $time, words_checked, what, got, want);
      error_count++;
   endtask

   // wait length per item; flips now and then into a stretch without waits
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 19) == 0)
         calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 16));
   endfunction

   // --------------------------------------------------------------------------
   // request driver: changes inputs on the falling edge
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait--;
         end else if (pending_requests.size() != 0) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
            req_wait  = draw_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // response ready: per-word random waits plus one long stall, so the block
   // backs up and holds off new requests while the driver keeps offering
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_wait = draw_gap(rsp_calm);
            if (!hold_done && words_checked >= HOLD_AFTER_WORDS) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------------
   // monitor: samples both handshakes on the rising edge, runs the model on
   // each accepted request and checks each accepted word against the oldest
   // expectation
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      lpbe_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            expand_request(req_data);
            n_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with none expected", rsp_data.spi_word, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.spi_word !== want.spi_word)
                  report_mismatch("spi_word", rsp_data.spi_word, want.spi_word);
               if (rsp_data.valid_bytes !== want.valid_bytes)
                  report_mismatch("valid_bytes", 64'(rsp_data.valid_bytes),
                                  64'(want.valid_bytes));
               if (rsp_data.word_is_last !== want.word_is_last)
                  report_mismatch("word_is_last", 64'(rsp_data.word_is_last),
                                  64'(want.word_is_last));
            end
            words_checked++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_words.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // sequence
   // --------------------------------------------------------------------------

   task automatic queue_request(input logic [7:0] color, input bit first, input bit last);
      lpbe_pkg::req_type r;
      r.color_byte  = color;
      r.frame_start = first;
      r.frame_end   = last;
      pending_requests.push_back(r);
      n_queued++;
   endtask

   // everything accepted and every word out; called on a falling edge
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (n_accepted != n_queued || expected_words.size() != 0);
   endtask

   // register writes only while idle; the model takes the new values with them
   task automatic set_config(input bit five_slot, input logic [lpbe_pkg::PAD_W-1:0] pads);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= lpbe_pkg::CSR_EXPANSION_MODE;
      csr_wdata    <= lpbe_pkg::CSR_DATA_W'(five_slot);
      @(negedge clock);
      csr_index    <= lpbe_pkg::CSR_PAD_WORD_COUNT;
      csr_wdata    <= lpbe_pkg::CSR_DATA_W'(pads);
      @(negedge clock);
      csr_write_en <= 1'b0;
      mode_five = five_slot;
      pad_words = pads;
      settings_seen++;
   endtask

   // mostly well-formed frames of random bytes, with truncated frames, stray
   // bytes between frames and frames with random flags mixed in
   task automatic queue_random_traffic(input int target);
      int added;
      int len;
      int kind;
      bit first;
      bit last;
      added = 0;
      while (added < target) begin
         kind = $urandom_range(0, 9);
         len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
         for (int k = 0; k < len; k++) begin
            first = (k == 0);
            last  = (k == len - 1);
            if (kind == 7) begin
               last = 1'b0;                 // left open, next start cuts it off
            end else if (kind == 8) begin
               first = 1'b0;                // bytes outside any frame
               last  = 1'b0;
            end else if (kind == 9) begin
               first = 1'($urandom_range(0, 1));
               last  = 1'($urandom_range(0, 1));
            end
            queue_request(8'($urandom_range(0, 255)), first, last);
            added++;
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset settings: three-bit mode, 15 pad words
      queue_request(8'h00, 1'b1, 1'b0);      // all-zero byte opens a frame
      queue_request(8'hFF, 1'b0, 1'b0);
      queue_request(8'h80, 1'b0, 1'b0);
      queue_request(8'h01, 1'b0, 1'b1);      // flush of a partial word
      queue_request(8'hAA, 1'b1, 1'b1);      // start and end on one byte
      queue_request(8'h55, 1'b0, 1'b0);      // bytes after a frame has ended
      queue_request(8'h3C, 1'b0, 1'b0);
      queue_request(8'hC3, 1'b1, 1'b0);      // start drops the stray bits
      queue_request(8'h0F, 1'b0, 1'b0);
      queue_request(8'hF0, 1'b1, 1'b0);      // start inside an open frame
      queue_request(8'h7E, 1'b0, 1'b1);

      // no pad words, three-bit mode: eight bytes fill exactly three words,
      // so the last flag sits on a full word; then a one-byte frame flushes
      set_config(1'b0, 4'd0);
      queue_request(8'hFF, 1'b1, 1'b0);
      repeat (6) queue_request(8'h00, 1'b0, 1'b0);
      queue_request(8'h81, 1'b0, 1'b1);
      queue_request(8'h5A, 1'b1, 1'b1);

      // no pad words, five-slot mode: two zero bytes make one exact word
      set_config(1'b1, 4'd0);
      queue_request(8'h00, 1'b1, 1'b0);
      queue_request(8'h00, 1'b0, 1'b1);
      queue_request(8'hFF, 1'b1, 1'b1);

      // random traffic under a spread of settings, extremes included
      set_config(1'b1, 4'd15);
      queue_random_traffic(30);
      set_config(1'b0, 4'd1);
      queue_random_traffic(30);
      set_config(1'b1, 4'd0);
      queue_random_traffic(30);
      set_config(1'b0, 4'd15);
      queue_random_traffic(30);
      set_config(1'b1, 4'd7);
      queue_random_traffic(30);
      set_config(1'b0, 4'd0);
      queue_random_traffic(30);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("ran %0d requests under %0d register settings, %0d words checked",
               n_accepted, settings_seen, words_checked);
      $display("long output stall of %0d cycles %s, %0d mismatches",
               HOLD_CYCLES, hold_done ? "exercised" : "not reached", error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lpbe_pkg.sv
hdl/lpbe_pack.sv
hdl/lpbe_emit.sv
hdl/led_pulse_bit_expander.sv
verif/tb_top.sv
